// ===== design/min_max_partition_search_macros.svh =====
// assertion macros used by the checker file
`ifndef MIN_MAX_PARTITION_SEARCH_MACROS_SVH
`define MIN_MAX_PARTITION_SEARCH_MACROS_SVH

// implication checked in the same cycle
`define MMPS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mmps check failed");

// implication checked in the next cycle
`define MMPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mmps check failed");

`endif

// ===== design/mmps_pkg.sv =====
// shared constants and types of the min/max partition search block
package mmps_pkg;

	localparam int PART_W     = 9;
	localparam int OUT_W      = 24;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [PART_W-1:0] PARTITIONS_RESET = 9'd2;

	// register index, taken from the word address bit of paddr
	localparam logic [0:0] REG_PARTITIONS = 1'b0;

	typedef struct packed {
		logic done;
		logic fits;
	} scan_status_t;

endpackage

// ===== design/mmps_if.sv =====
// valid/ready channels for input items and result items
interface mmps_item_if #(
	parameter int VALUE_BITS = 16
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] item_value;
	logic                  last_item;

	modport source (output valid, item_value, last_item, input ready);
	modport sink   (input valid, item_value, last_item, output ready);
endinterface

interface mmps_result_if;
	logic                         valid;
	logic                         ready;
	logic [mmps_pkg::OUT_W-1:0]   min_max_sum;
	logic                         overflowed;

	modport source (output valid, min_max_sum, overflowed, input ready);
	modport sink   (input valid, min_max_sum, overflowed, output ready);
endinterface

// ===== design/mmps_ram.sv =====
// generic single write port, single read port ram with registered read
module mmps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/mmps_scan.sv =====
// greedy feasibility pass over the stored items for one trial bound
module mmps_scan #(
	parameter int VALUE_BITS = 16,
	parameter int MAX_ITEMS  = 256
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic [VALUE_BITS+$clog2(MAX_ITEMS+1):0] bound,
	input  logic [$clog2(MAX_ITEMS+1)-1:0]         count,
	input  logic [mmps_pkg::PART_W-1:0]            partitions,
	output logic                                   rd_en,
	output logic [(MAX_ITEMS > 1 ? $clog2(MAX_ITEMS) : 1)-1:0] rd_addr,
	input  logic [VALUE_BITS-1:0]                  rd_data,
	output mmps_pkg::scan_status_t                 status
);

	localparam int CW  = $clog2(MAX_ITEMS + 1);
	localparam int AW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int SW  = VALUE_BITS + CW + 1;
	localparam int PCW = mmps_pkg::PART_W + 1;

	logic           running_q;
	logic [CW-1:0]  issue_idx_q;
	logic           pend_s1;
	logic [SW-1:0]  part_sum_q;
	logic [PCW-1:0] part_count_q;
	logic           done_q;
	logic           fits_q;

	logic           issue;
	logic [SW-1:0]  value_ext;
	logic [SW-1:0]  sum;
	logic           sum_fits;
	logic [PCW-1:0] count_next;
	logic           fail;
	logic           all_issued;

	always_comb begin
		issue      = running_q && (issue_idx_q < count);
		value_ext  = SW'(rd_data);
		sum        = part_sum_q + value_ext;
		sum_fits   = (sum <= bound);
		count_next = part_count_q + PCW'(1);
		// a new part that is one too many, or an item that cannot fit alone
		fail       = (count_next > PCW'(partitions)) || (value_ext > bound);
		all_issued = (issue_idx_q == count);
	end

	assign rd_en       = issue;
	assign rd_addr     = issue_idx_q[AW-1:0];
	assign status.done = done_q;
	assign status.fits = fits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q    <= 1'b0;
			issue_idx_q  <= '0;
			pend_s1      <= 1'b0;
			part_sum_q   <= '0;
			part_count_q <= '0;
			done_q       <= 1'b0;
			fits_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q    <= (count != '0);
				issue_idx_q  <= '0;
				pend_s1      <= 1'b0;
				part_sum_q   <= '0;
				part_count_q <= PCW'(1);
				if (count == '0) begin
					done_q <= 1'b1;
					fits_q <= 1'b1;
				end
			end else if (running_q) begin
				pend_s1 <= issue;
				if (issue) begin
					issue_idx_q <= issue_idx_q + CW'(1);
				end
				if (pend_s1) begin
					if (sum_fits) begin
						part_sum_q <= sum;
					end else begin
						part_count_q <= count_next;
						part_sum_q   <= value_ext;
					end
					if (!sum_fits && fail) begin
						running_q <= 1'b0;
						pend_s1   <= 1'b0;
						done_q    <= 1'b1;
						fits_q    <= 1'b0;
					end else if (all_issued) begin
						// last stored item has just been taken in
						running_q <= 1'b0;
						done_q    <= 1'b1;
						fits_q    <= 1'b1;
					end
				end
			end
		end
	end

endmodule

// ===== design/min_max_partition_search.sv =====
// top level of the min/max partition search block
//
// items (sink): one transaction per sequence element, item_value plus a
//   last_item mark; elements beyond MAX_ITEMS are dropped and flagged
// results (source): one transaction per sequence, min_max_sum and overflowed
// apb port: register partitions at word 0, written in the access phase
//
// loading takes one element per cycle, ready stays high while loading
// after the last element the block runs a binary search over [0, total];
//   each round is one greedy pass over the stored elements through a shared
//   add/compare unit fed by the item ram, and the search takes up to
//   VALUE_BITS + clog2(MAX_ITEMS + 1) + 1 rounds; items.ready is low for
//   the whole search
// the result sits in an output register, so loading of the next sequence
//   goes on while the receiver stalls; a second result waits in the search
//   sequencer until the register frees up
// reset clears counts, the total, the drop flag, the output register and
//   sets partitions to 2; the item ram is not cleared, only written entries
//   are ever read
module min_max_partition_search #(
	parameter int VALUE_BITS = 16,
	parameter int MAX_ITEMS  = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	mmps_item_if.sink                           items,
	mmps_result_if.source                       results,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mmps_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [mmps_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [mmps_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int TW = VALUE_BITS + CW;
	localparam int SW = TW + 1;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_MID,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t                          state_q;
	logic [mmps_pkg::PART_W-1:0]     partitions_q;
	logic [CW-1:0]                   count_q;
	logic [TW-1:0]                   total_q;
	logic                            drop_q;
	logic [SW-1:0]                   low_q;
	logic [SW-1:0]                   high_q;
	logic [SW-1:0]                   mid_q;
	logic [SW-1:0]                   best_q;
	logic                            scan_start_q;
	logic                            out_valid_q;
	logic [mmps_pkg::OUT_W-1:0]      out_sum_q;
	logic                            out_ovf_q;

	logic                            in_acc;
	logic                            store;
	logic [TW-1:0]                   total_next;
	logic [SW:0]                     mid_sum;
	logic                            cfg_write;

	logic                            ram_re;
	logic [AW-1:0]                   ram_raddr;
	logic [VALUE_BITS-1:0]           ram_rdata;
	mmps_pkg::scan_status_t          scan_status;

	// apb register port, no wait states
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == mmps_pkg::REG_PARTITIONS)
		? mmps_pkg::APB_DATA_W'(partitions_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partitions_q <= mmps_pkg::PARTITIONS_RESET;
		end else if (cfg_write && (paddr[2] == mmps_pkg::REG_PARTITIONS)) begin
			partitions_q <= pwdata[mmps_pkg::PART_W-1:0];
		end
	end

	// loader: store while there is room, keep a running total
	assign items.ready = (state_q == ST_LOAD);
	assign in_acc      = items.valid && items.ready;
	assign store       = in_acc && (count_q < CW'(MAX_ITEMS));
	assign total_next  = total_q + (store ? TW'(items.item_value) : '0);

	// midpoint of the search window, low <= high here
	assign mid_sum = (SW + 1)'(low_q) + (SW + 1)'(high_q);

	assign results.valid       = out_valid_q;
	assign results.min_max_sum = out_sum_q;
	assign results.overflowed  = out_ovf_q;

	mmps_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (MAX_ITEMS)
	) u_ram (
		.clk   (clk),
		.we    (store),
		.waddr (count_q[AW-1:0]),
		.wdata (items.item_value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// shared add/compare unit, one greedy pass per trial bound
	mmps_scan #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_ITEMS  (MAX_ITEMS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (scan_start_q),
		.bound      (mid_q),
		.count      (count_q),
		.partitions (partitions_q),
		.rd_en      (ram_re),
		.rd_addr    (ram_raddr),
		.rd_data    (ram_rdata),
		.status     (scan_status)
	);

	// search sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			count_q      <= '0;
			total_q      <= '0;
			drop_q       <= 1'b0;
			low_q        <= '0;
			high_q       <= '0;
			mid_q        <= '0;
			best_q       <= '0;
			scan_start_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_sum_q    <= '0;
			out_ovf_q    <= 1'b0;
		end else begin
			scan_start_q <= 1'b0;
			if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						total_q <= total_next;
						if (store) begin
							count_q <= count_q + CW'(1);
						end else begin
							drop_q <= 1'b1;
						end
						if (items.last_item) begin
							low_q   <= '0;
							high_q  <= SW'(total_next);
							best_q  <= SW'(total_next);
							state_q <= ST_MID;
						end
					end
				end
				ST_MID: begin
					if (low_q > high_q) begin
						state_q <= ST_FINISH;
					end else begin
						mid_q        <= mid_sum[SW:1];
						scan_start_q <= 1'b1;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_status.done) begin
						if (scan_status.fits) begin
							best_q <= mid_q;
							if (mid_q == '0) begin
								state_q <= ST_FINISH;
							end else begin
								high_q  <= mid_q - SW'(1);
								state_q <= ST_MID;
							end
						end else begin
							low_q   <= mid_q + SW'(1);
							state_q <= ST_MID;
						end
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || results.ready) begin
						out_valid_q <= 1'b1;
						out_sum_q   <= mmps_pkg::OUT_W'(best_q);
						out_ovf_q   <= drop_q;
						count_q     <= '0;
						total_q     <= '0;
						drop_q      <= 1'b0;
						state_q     <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

// ===== design/mmps_checker.sv =====
// port-level checks of the min/max partition search block and their bind
`include "min_max_partition_search_macros.svh"

module mmps_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           in_last,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [mmps_pkg::OUT_W-1:0]     out_sum,
	input logic                           out_ovf
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// a stalled result holds its value
	`MMPS_ASSERT_NEXT(a_result_held, out_valid && !out_ready,
		out_valid && $stable(out_sum) && $stable(out_ovf))

	// the last element starts a search, no element is taken next cycle
	`MMPS_ASSERT_NEXT(a_search_blocks, in_acc && in_last, !in_ready)

	// loading goes on without a gap until the last element
	`MMPS_ASSERT_NEXT(a_load_streams, in_acc && !in_last, in_ready)

	// a new result only comes out of a search
	`MMPS_ASSERT_NOW(a_result_from_search, $rose(out_valid), $past(!in_ready))

endmodule

bind min_max_partition_search mmps_checker u_mmps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (items.valid),
	.in_ready  (items.ready),
	.in_last   (items.last_item),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_sum   (results.min_max_sum),
	.out_ovf   (results.overflowed)
);

// ===== sim/min_max_partition_search_tb.sv =====
// self-checking testbench of the min/max partition search block
`timescale 1ns / 100ps

module min_max_partition_search_tb;

	localparam int VALUE_BITS    = 16;
	localparam int MAX_ITEMS     = 256;
	// search of a full store: at most about 24 rounds, each a pass over the
	// stored items; the end pause covers that with room to spare
	localparam int DRAIN_CYCLES  = 8000;
	localparam int SETTLE_CYCLES = 64;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int LONG_HOLD     = 2000;
	localparam int MAX_GAP       = 18;

	// partitions sits at word 0, the other word decodes to an unused index
	localparam logic [mmps_pkg::APB_ADDR_W-1:0] PARTITIONS_ADDR =
		{mmps_pkg::REG_PARTITIONS, 2'b00};
	localparam logic [mmps_pkg::APB_ADDR_W-1:0] SPARE_ADDR      =
		{~mmps_pkg::REG_PARTITIONS, 2'b00};

	typedef enum int {
		W_FULL,
		W_SMALL,
		W_EXTREME
	} weight_kind_t;

	typedef logic [VALUE_BITS-1:0] weight_q_t[$];

	typedef struct packed {
		logic [mmps_pkg::OUT_W-1:0] min_max_sum;
		logic                       overflowed;
	} bound_result_t;

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [mmps_pkg::APB_ADDR_W-1:0] paddr;
	logic [mmps_pkg::APB_DATA_W-1:0] pwdata;
	logic [mmps_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;

	mmps_item_if #(.VALUE_BITS(VALUE_BITS)) item_ch ();
	mmps_result_if                          result_ch ();

	min_max_partition_search #(
		.VALUE_BITS(VALUE_BITS),
		.MAX_ITEMS (MAX_ITEMS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (item_ch),
		.results(result_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// own copy of the block's state: stored weights, count, total, drop mark
	logic [VALUE_BITS-1:0]       held_values [MAX_ITEMS];
	int                          held_count;
	logic [mmps_pkg::OUT_W-1:0]  held_total;
	logic                        dropped_any;
	logic [mmps_pkg::PART_W-1:0] part_limit;

	// bounds still owed by the block, oldest first
	bound_result_t pending_bounds[$];

	int mismatches;

	// idle control: steady sides never pause, hold request is one long stall
	bit tx_steady;
	bit rx_steady;
	int rx_hold_request;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic note_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch in %s: expected %0d, got %0d", what, want, got);
		end
	endtask

	// greedy left-to-right split: does every part stay within bound while
	// using no more than part_limit parts
	function automatic bit split_fits(input logic [mmps_pkg::OUT_W:0] bound);
		logic [mmps_pkg::OUT_W:0] part_sum;
		int                       parts;
		parts    = 1;
		part_sum = '0;
		for (int i = 0; i < held_count; i++) begin
			if (part_sum + held_values[i] <= bound) begin
				part_sum = part_sum + held_values[i];
			end else begin
				parts++;
				if (parts > part_limit || held_values[i] > bound) begin
					return 1'b0;
				end
				part_sum = held_values[i];
			end
		end
		return 1'b1;
	endfunction

	// binary search over [0, total] for the smallest bound that splits
	function automatic logic [mmps_pkg::OUT_W-1:0] min_largest_part_sum();
		logic [mmps_pkg::OUT_W:0] lo;
		logic [mmps_pkg::OUT_W:0] hi;
		logic [mmps_pkg::OUT_W:0] mid;
		logic [mmps_pkg::OUT_W:0] best;
		lo   = '0;
		hi   = held_total;
		best = held_total;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (split_fits(mid)) begin
				best = mid;
				if (mid == 0) begin
					break;
				end
				hi = mid - 1;
			end else begin
				lo = mid + 1;
			end
		end
		return best[mmps_pkg::OUT_W-1:0];
	endfunction

	// one accepted item: store it or mark the drop, and on the last one work
	// out the bound and start a fresh sequence
	task automatic take_item(input logic [VALUE_BITS-1:0] value, input logic last);
		bound_result_t bound;
		if (held_count < MAX_ITEMS) begin
			held_values[held_count] = value;
			held_count++;
			held_total = held_total + value;
		end else begin
			dropped_any = 1'b1;
		end
		if (last) begin
			bound.min_max_sum = min_largest_part_sum();
			bound.overflowed  = dropped_any;
			pending_bounds.push_back(bound);
			held_count  = 0;
			held_total  = '0;
			dropped_any = 1'b0;
		end
	endtask

	function automatic logic [VALUE_BITS-1:0] draw_weight(input weight_kind_t kind);
		case (kind)
			W_SMALL: begin
				return VALUE_BITS'($urandom_range(0, 15));
			end
			W_EXTREME: begin
				return ($urandom_range(0, 1) != 0) ? {VALUE_BITS{1'b1}} : '0;
			end
			default: begin
				return VALUE_BITS'($urandom());
			end
		endcase
	endfunction

	// one item transaction; valid stays high at the end so a back-to-back
	// item goes out without a bubble
	task automatic send_item(input logic [VALUE_BITS-1:0] value, input logic last);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.item_value <= value;
		item_ch.last_item  <= last;
		do @(posedge clk); while (!item_ch.ready);
		take_item(value, last);
	endtask

	task automatic send_seq(input weight_q_t weights);
		foreach (weights[i]) begin
			send_item(weights[i], i == weights.size() - 1);
		end
	endtask

	task automatic send_random_seq(input int len, input weight_kind_t kind);
		tx_steady = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < len; i++) begin
			send_item(draw_weight(kind), i == len - 1);
		end
	endtask

	function automatic weight_kind_t pick_kind();
		case ($urandom_range(0, 5))
			0, 1, 2: return W_FULL;
			3, 4:    return W_SMALL;
			default: return W_EXTREME;
		endcase
	endfunction

	// drop valid, let every owed bound come back, then a short settle
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		while (pending_bounds.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// the bus goes idle after the access phase, before the task returns
	task automatic apb_write(input logic [mmps_pkg::APB_ADDR_W-1:0] addr,
			input logic [mmps_pkg::APB_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == PARTITIONS_ADDR) begin
			part_limit = data[mmps_pkg::PART_W-1:0];
		end
		@(posedge clk);
	endtask

	task automatic apb_read(input logic [mmps_pkg::APB_ADDR_W-1:0] addr,
			output logic [mmps_pkg::APB_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		// prdata as held through the access phase
		data = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_partitions_readback();
		logic [mmps_pkg::APB_DATA_W-1:0] readback;
		apb_read(PARTITIONS_ADDR, readback);
		if (readback[mmps_pkg::PART_W-1:0] !== part_limit) begin
			note_mismatch("partitions readback", part_limit,
				readback[mmps_pkg::PART_W-1:0]);
		end
	endtask

	// upper data bits are random, only the low PART_W bits matter
	task automatic set_partitions(input logic [mmps_pkg::PART_W-1:0] value);
		logic [mmps_pkg::APB_DATA_W-1:0] data;
		wait_idle();
		data                       = $urandom();
		data[mmps_pkg::PART_W-1:0] = value;
		apb_write(PARTITIONS_ADDR, data);
		check_partitions_readback();
	endtask

	// result side: a random stall per transaction, or the long hold when
	// one is requested; the stall length is counted here
	initial begin : result_drain
		int stall;
		result_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_request > 0) begin
				stall           = rx_hold_request;
				rx_hold_request = 0;
			end else begin
				stall = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	// every result transaction is matched against the oldest owed bound
	always @(posedge clk) begin : check_bounds
		bound_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_bounds.size() == 0) begin
				note_mismatch("result with nothing owed", 0, result_ch.min_max_sum);
			end else begin
				want = pending_bounds.pop_front();
				if (result_ch.min_max_sum !== want.min_max_sum) begin
					note_mismatch("min_max_sum", want.min_max_sum, result_ch.min_max_sum);
				end
				if (result_ch.overflowed !== want.overflowed) begin
					note_mismatch("overflowed", want.overflowed, result_ch.overflowed);
				end
			end
		end
	end

	// hard stop in case the block hangs
	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("min_max_partition_search regression: fail");
		$finish;
	end

	// partitions must come out of reset at 2
	task automatic test_reset_state();
		check_partitions_readback();
		send_seq('{16'd3, 16'd4});
	endtask

	// single zero ends the search on a zero bound, max weights push the total
	task automatic test_value_extremes();
		send_seq('{16'd0});
		send_seq('{16'hFFFF});
		send_seq('{16'hFFFF, 16'hFFFF, 16'hFFFF});
		send_seq('{16'hAAAA, 16'h5555, 16'd0, 16'd1});
	endtask

	// one part and zero parts both give the total; wide limits give the max
	task automatic test_partition_extremes();
		set_partitions(9'd1);
		send_seq('{16'd5, 16'd7, 16'd9});
		set_partitions(9'd0);
		send_seq('{16'd5, 16'd7, 16'd9});
		set_partitions(9'd256);
		send_seq('{16'd300, 16'hFFFF, 16'd2});
		set_partitions(9'h1FF);
		send_seq('{16'd1, 16'd2});
	endtask

	// a write to the unused index must not touch partitions
	task automatic test_spare_register();
		wait_idle();
		apb_write(SPARE_ADDR, 32'd1);
		check_partitions_readback();
		send_seq('{16'd9, 16'd1, 16'd8});
	endtask

	// exactly full store, then one more so the last item itself is dropped
	task automatic test_store_full();
		set_partitions(9'd4);
		rx_steady = 1'b0;
		send_random_seq(MAX_ITEMS, W_FULL);
		set_partitions(9'd3);
		send_random_seq(MAX_ITEMS + 1, W_SMALL);
	endtask

	// receiver holds off while short sequences keep coming, so the output
	// register and the sequencer fill and item ready goes low
	task automatic test_backpressure();
		set_partitions(9'd2);
		rx_steady       = 1'b1;
		rx_hold_request = LONG_HOLD;
		for (int n = 0; n < 8; n++) begin
			send_random_seq($urandom_range(1, 6), W_FULL);
		end
		wait_idle();
		rx_steady = 1'b0;
	endtask

	// mostly short sequences, partitions changed now and then
	task automatic test_random_sequences(input int item_budget);
		int sent;
		int len;
		sent = 0;
		while (sent < item_budget) begin
			if ($urandom_range(0, 99) < 8) begin
				case ($urandom_range(0, 9))
					0:       set_partitions(9'd0);
					1:       set_partitions(9'd1);
					2:       set_partitions(9'd256);
					3:       set_partitions(9'h1FF);
					4:       set_partitions(mmps_pkg::PART_W'($urandom_range(257, 510)));
					default: set_partitions(mmps_pkg::PART_W'($urandom_range(2, 8)));
				endcase
				rx_steady = ($urandom_range(0, 3) == 0);
			end
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
			send_random_seq(len, pick_kind());
			sent += len;
		end
	endtask

	initial begin : stimulus
		arst_n             <= 1'b0;
		psel               <= 1'b0;
		penable            <= 1'b0;
		pwrite             <= 1'b0;
		paddr              <= '0;
		pwdata             <= '0;
		item_ch.valid      <= 1'b0;
		item_ch.item_value <= '0;
		item_ch.last_item  <= 1'b0;

		held_count      = 0;
		held_total      = '0;
		dropped_any     = 1'b0;
		part_limit      = mmps_pkg::PARTITIONS_RESET;
		mismatches      = 0;
		tx_steady       = 1'b0;
		rx_steady       = 1'b0;
		rx_hold_request = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_value_extremes();
		test_partition_extremes();
		test_spare_register();
		test_backpressure();
		test_store_full();
		test_random_sequences(560);

		// everything sent: wait for the owed bounds, then watch for strays
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_bounds.size() == 0) begin
			$display("min_max_partition_search regression: pass");
		end else begin
			$display("min_max_partition_search regression: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/mmps_pkg.sv
design/mmps_if.sv
design/mmps_ram.sv
design/mmps_scan.sv
design/min_max_partition_search.sv
design/mmps_checker.sv
sim/min_max_partition_search_tb.sv
